/* sv/tet_pkg.sv */
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the terminal escape tokenizer.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [BYTE_W-1:0] CTRL_OFS = 8'h40;

    typedef enum logic [6:0] {
        MODE_NORMAL  = 7'b0000001,
        MODE_ESCAPE  = 7'b0000010,
        MODE_CSI     = 7'b0000100,
        MODE_OSC     = 7'b0001000,
        MODE_DCS     = 7'b0010000,
        MODE_CHARSET = 7'b0100000,
        MODE_LINEATT = 7'b1000000
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        K_LITERAL  = 4'd0,
        K_CARRIAGE = 4'd1,
        K_NEWLINE  = 4'd2,
        K_ESCFINAL = 4'd3,
        K_CHARSET  = 4'd4,
        K_LINEATT  = 4'd5,
        K_CSIBODY  = 4'd6,
        K_CSIEND   = 4'd7,
        K_OSCBODY  = 4'd8,
        K_OSCEND   = 4'd9,
        K_DCSBODY  = 4'd10,
        K_DCSEND   = 4'd11
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_res;

    typedef struct packed {
        t_mode      mode;
        logic       held;
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_dec;

endpackage

/* sv/tet_decode.sv */
// ----------------------------------------------------------------------------
// tet_decode
// Combinational tokenizer step: parser state and one byte in, next state
// and up to two result tokens out.
// ----------------------------------------------------------------------------
module tet_decode (
    input  tet_pkg::t_mode              i_mode,
    input  logic                        i_held,
    input  logic [tet_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_restart,
    output tet_pkg::t_dec               o_dec
);
    import tet_pkg::*;

    t_mode             mode_eff;
    logic              held_eff;
    logic [BYTE_W-1:0] b;
    t_kind             k0, k1, ek, bk, endk;
    logic [BYTE_W-1:0] v0, v1, ev;
    logic              e_has;

    assign b        = i_byte;
    assign mode_eff = i_restart ? MODE_NORMAL : i_mode;
    assign held_eff = i_restart ? 1'b0 : i_held;

    always_comb begin
        o_dec.mode = MODE_NORMAL;
        o_dec.held = held_eff;
        o_dec.cnt  = 2'd0;
        k0 = K_LITERAL;
        v0 = b;
        k1 = K_LITERAL;
        v1 = b;
        ek = K_LITERAL;
        ev = b;
        e_has = 1'b0;
        bk   = (mode_eff == MODE_OSC) ? K_OSCBODY : K_DCSBODY;
        endk = (mode_eff == MODE_OSC) ? K_OSCEND  : K_DCSEND;
        case (mode_eff)
            MODE_ESCAPE: begin
                if (b == CH_LBRK) begin
                    o_dec.mode = MODE_CSI;
                end else if (b == CH_HASH) begin
                    o_dec.mode = MODE_LINEATT;
                end else if (b == CH_RBRK) begin
                    o_dec.mode = MODE_OSC;
                    o_dec.held = 1'b0;
                end else if (b == CH_P) begin
                    o_dec.mode = MODE_DCS;
                    o_dec.held = 1'b0;
                end else if (b == CH_LPAR) begin
                    o_dec.mode = MODE_CHARSET;
                end else begin
                    k0 = K_ESCFINAL;
                    o_dec.cnt = 2'd1;
                end
            end
            MODE_CHARSET: begin
                k0 = K_CHARSET;
                o_dec.cnt = 2'd1;
            end
            MODE_LINEATT: begin
                k0 = K_LINEATT;
                o_dec.cnt = 2'd1;
            end
            MODE_CSI: begin
                k0 = K_CSIBODY;
                o_dec.mode = MODE_CSI;
                o_dec.cnt = 2'd1;
                if (b inside {[8'h40:8'h7E]}) begin
                    k1 = K_CSIEND;
                    o_dec.cnt = 2'd2;
                    o_dec.mode = MODE_NORMAL;
                end
            end
            MODE_OSC, MODE_DCS: begin
                o_dec.mode = mode_eff;
                if (held_eff && b == CH_BSL) begin
                    o_dec.held = 1'b0;
                    o_dec.mode = MODE_NORMAL;
                    k0 = endk;
                    o_dec.cnt = 2'd1;
                end else begin
                    o_dec.held = 1'b0;
                    // The token this byte makes on its own, placed after a
                    // released ESC when one was held.
                    if (mode_eff == MODE_OSC && b == CH_BEL) begin
                        o_dec.mode = MODE_NORMAL;
                        ek = endk;
                        e_has = 1'b1;
                    end else if (b == CH_ESC) begin
                        o_dec.held = 1'b1;
                    end else begin
                        ek = bk;
                        e_has = 1'b1;
                    end
                    if (held_eff) begin
                        k0 = bk;
                        v0 = CH_ESC;
                        k1 = ek;
                        v1 = ev;
                        o_dec.cnt = e_has ? 2'd2 : 2'd1;
                    end else begin
                        k0 = ek;
                        v0 = ev;
                        o_dec.cnt = e_has ? 2'd1 : 2'd0;
                    end
                end
            end
            default: begin
                if (b == CH_ESC) begin
                    o_dec.mode = MODE_ESCAPE;
                end else if (b == CH_CR) begin
                    k0 = K_CARRIAGE;
                    o_dec.cnt = 2'd1;
                end else if (b == CH_LF) begin
                    k0 = K_NEWLINE;
                    o_dec.cnt = 2'd1;
                end else if (b[BYTE_W-1] || (b inside {[8'h20:8'h7E]})) begin
                    k0 = K_LITERAL;
                    o_dec.cnt = 2'd1;
                end else if (b inside {[8'h00:8'h1F]}) begin
                    k0 = K_LITERAL;
                    v0 = CH_CARET;
                    k1 = K_LITERAL;
                    v1 = b + CTRL_OFS;
                    o_dec.cnt = 2'd2;
                end else begin
                    k0 = K_LITERAL;
                    v0 = CH_DOT;
                    o_dec.cnt = 2'd1;
                end
            end
        endcase
        o_dec.res0 = '{kind: k0, value: v0, last: (o_dec.cnt == 2'd1)};
        o_dec.res1 = '{kind: k1, value: v1, last: 1'b1};
    end

endmodule

/* sv/tet_res_fifo.sv */
// ----------------------------------------------------------------------------
// tet_res_fifo
// Small result queue that takes zero, one or two tokens per cycle and
// hands out one per cycle while the reader pops.
// ----------------------------------------------------------------------------
module tet_res_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  tet_pkg::t_res              i_res0,
    input  tet_pkg::t_res              i_res1,
    input  logic                       i_pop,
    output logic                       o_room,
    output logic                       o_valid,
    output tet_pkg::t_res              o_res,
    output logic [tet_pkg::CNT_W-1:0]  o_count
);
    import tet_pkg::*;

    t_res             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr1;
    logic             pop;

    assign wr1     = r_wr + PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    // Room for a full pair, whatever leaves this cycle.
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_count = r_count;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push_cnt);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + CNT_W'(i_push_cnt) - CNT_W'(pop);
        end
    end

endmodule

/* sv/terminal_escape_tokenizer.sv */
// ----------------------------------------------------------------------------
// terminal_escape_tokenizer
// Tokenizes a terminal byte stream into text, control and escape-sequence
// events.
// ----------------------------------------------------------------------------
// One byte is taken per transfer on the slave side, and the block accepts a
// byte in every cycle as long as its four-entry result queue has room for a
// pair of tokens. A byte is held in the input register until the queue has
// room, decoded there against the parser mode and the held-ESC flag, and its
// tokens (none, one or two) are written into the result queue; the first
// token is offered from there. The output side moves one token per transfer.
// A byte that makes two tokens (a control character shown as '^' and a
// letter, a CSI final byte with its end event, or a released ESC followed by
// the current byte) occupies the output for both of its tokens. The
// sustained rate is one byte per cycle for ordinary text while the output
// side is ready, and drops to the output rate while two-token bytes arrive.
// tlast marks the last token that a byte produces; bytes that only change
// mode produce nothing.
// Setting the restart flag in tuser returns the parser to normal mode and
// drops any held ESC before that byte is decoded.
// ----------------------------------------------------------------------------
module terminal_escape_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic [0:0]  i_s_axis_tuser,   // [0] restart
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] value
    output logic [3:0]  o_m_axis_tuser,   // [3:0] kind
    output logic        o_m_axis_tlast
);
    import tet_pkg::*;

    // Input register.
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_restart;

    // Parser state.
    t_mode r_mode;
    logic  r_held;

    t_dec             dec;
    t_res             res_out;
    logic             room;
    logic             consume;
    logic [1:0]       push_cnt;
    logic [CNT_W-1:0] q_count;

    // The byte in the input register is decoded and retired only when the
    // queue can take both of its possible tokens.
    assign consume         = r_in_vld && room;
    assign o_s_axis_tready = !r_in_vld || consume;
    assign push_cnt        = consume ? dec.cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte    <= i_s_axis_tdata;
            r_in_restart <= i_s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_held <= 1'b0;
        end else if (consume) begin
            r_mode <= dec.mode;
            r_held <= dec.held;
        end
    end

    tet_decode u_decode (
        .i_mode    (r_mode),
        .i_held    (r_held),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_dec     (dec)
    );

    tet_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (dec.res0),
        .i_res1     (dec.res1),
        .i_pop      (i_m_axis_tready),
        .o_room     (room),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (res_out),
        .o_count    (q_count)
    );

    assign o_m_axis_tdata = res_out.value;
    assign o_m_axis_tuser = res_out.kind;
    assign o_m_axis_tlast = res_out.last;

    // The queue never holds more than its depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A token without tlast is always followed by its partner in the queue.
    a_pair_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (q_count >= CNT_W'(2)))
        else $error("first token of a pair without its second");

    // An ESC is only ever held inside an OSC or DCS string.
    a_held_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_mode == MODE_OSC || r_mode == MODE_DCS))
        else $error("held ESC outside OSC or DCS");

    // The parser state moves only when a byte is decoded.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !consume |=> ($stable(r_mode) && $stable(r_held)))
        else $error("parser state changed without a byte");

endmodule
